@@ rtl/ps2mpt_pkg.sv @@
`timescale 1ns / 1ps
package ps2mpt_pkg;

   localparam int CFG_BITS = 12;

   // configuration register indexes
   localparam logic [1:0] CSR_TRACKING = 2'd0;
   localparam logic [1:0] CSR_MAX_X    = 2'd1;
   localparam logic [1:0] CSR_MAX_Y    = 2'd2;

   localparam logic [CFG_BITS-1:0] MAX_X_RESET = 12'd640;
   localparam logic [CFG_BITS-1:0] MAX_Y_RESET = 12'd480;

   localparam int CURSOR_X_RESET = 320;
   localparam int CURSOR_Y_RESET = 240;

   // click codes
   localparam logic [1:0] CLICK_NONE  = 2'd0;
   localparam logic [1:0] CLICK_LEFT  = 2'd1;
   localparam logic [1:0] CLICK_RIGHT = 2'd2;

   typedef struct packed {
      logic                tracking_enabled;
      logic [CFG_BITS-1:0] max_x;
      logic [CFG_BITS-1:0] max_y;
   } cfg_type;

endpackage

@@ rtl/ps2mpt_csr.sv @@
`timescale 1ns / 1ps
module ps2mpt_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wen,
   input  logic [1:0]                   csr_index,
   input  logic [ps2mpt_pkg::CFG_BITS-1:0] csr_wdata,
   output ps2mpt_pkg::cfg_type          cfg
);
   import ps2mpt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_TRACKING: cfg_in.tracking_enabled = csr_wdata[0];
            CSR_MAX_X:    cfg_in.max_x = csr_wdata;
            CSR_MAX_Y:    cfg_in.max_y = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tracking_enabled <= 1'b1;
         cfg_ff.max_x <= MAX_X_RESET;
         cfg_ff.max_y <= MAX_Y_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/ps2mpt_core.sv @@
`timescale 1ns / 1ps
module ps2mpt_core #(
   parameter int POS_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  ps2mpt_pkg::cfg_type cfg,
   input  logic                fire,
   input  logic [7:0]          data_byte,
   output logic                emit,
   output logic [POS_BITS-1:0] res_x,
   output logic [POS_BITS-1:0] res_y,
   output logic [1:0]          res_click
);
   import ps2mpt_pkg::*;

   // two guard bits: room for the sign and for a carry past the top
   localparam int SW = POS_BITS + 2;
   localparam logic [SW-1:0] POS_TOP = {2'b00, {POS_BITS{1'b1}}};

   typedef enum logic [1:0] {
      IDX_HEADER  = 2'd0,
      IDX_X_DELTA = 2'd1,
      IDX_Y_DELTA = 2'd2
   } index_type;

   index_type           idx_ff, idx_in;
   logic [POS_BITS-1:0] cursor_x_ff, cursor_x_in;
   logic [POS_BITS-1:0] cursor_y_ff, cursor_y_in;
   logic                left_ff, left_in;
   logic                right_ff, right_in;
   logic                x_neg_ff, x_neg_in;
   logic                y_neg_ff, y_neg_in;

   logic signed [SW-1:0] delta_x;
   logic signed [SW-1:0] delta_y;
   logic signed [SW-1:0] sum_x;
   logic signed [SW-1:0] sum_y;
   logic [POS_BITS-1:0]  clamp_x;
   logic [POS_BITS-1:0]  clamp_y;

   function automatic logic [POS_BITS-1:0] clamp_pos(input logic signed [SW-1:0] v,
                                                     input logic [CFG_BITS-1:0] bound);
      logic [SW-1:0] b_ext;
      logic [SW-1:0] lim;
      b_ext = SW'(bound);
      lim = (b_ext > POS_TOP) ? POS_TOP : b_ext;
      if (v[SW-1])
         return '0;
      else if ($unsigned(v) > lim)
         return lim[POS_BITS-1:0];
      else
         return v[POS_BITS-1:0];
   endfunction

   assign delta_x = SW'($signed({x_neg_ff, data_byte}));
   assign delta_y = SW'($signed({y_neg_ff, data_byte}));
   assign sum_x   = $signed({2'b00, cursor_x_ff}) + delta_x;
   assign sum_y   = $signed({2'b00, cursor_y_ff}) - delta_y;
   assign clamp_x = clamp_pos(sum_x, cfg.max_x);
   assign clamp_y = clamp_pos(sum_y, cfg.max_y);

   always_comb begin
      idx_in      = idx_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      x_neg_in    = x_neg_ff;
      y_neg_in    = y_neg_ff;
      if (fire && cfg.tracking_enabled) begin
         case (idx_ff)
            IDX_X_DELTA: begin
               cursor_x_in = clamp_x;
               idx_in = IDX_Y_DELTA;
            end
            IDX_Y_DELTA: begin
               cursor_y_in = clamp_y;
               idx_in = IDX_HEADER;
            end
            default: begin
               // header byte; the unused index code also lands here
               left_in  = data_byte[0];
               right_in = data_byte[1];
               x_neg_in = data_byte[4];
               y_neg_in = data_byte[5];
               idx_in   = IDX_X_DELTA;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= IDX_HEADER;
         cursor_x_ff <= POS_BITS'(CURSOR_X_RESET);
         cursor_y_ff <= POS_BITS'(CURSOR_Y_RESET);
         left_ff     <= 1'b0;
         right_ff    <= 1'b0;
         x_neg_ff    <= 1'b0;
         y_neg_ff    <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         left_ff     <= left_in;
         right_ff    <= right_in;
         x_neg_ff    <= x_neg_in;
         y_neg_ff    <= y_neg_in;
      end
   end

   assign emit      = cfg.tracking_enabled && (idx_ff == IDX_Y_DELTA);
   assign res_x     = cursor_x_ff;
   assign res_y     = clamp_y;
   assign res_click = left_ff ? CLICK_LEFT : (right_ff ? CLICK_RIGHT : CLICK_NONE);

endmodule

@@ rtl/ps2_mouse_packet_tracker.sv @@
`timescale 1ns / 1ps
// PS/2 mouse packet tracker.
// req_ carries raw mouse bytes, one per beat; every third byte of a packet
// (header, X delta, Y delta) produces one rsp_ beat with the clamped cursor
// position and a click code (left wins over right). While tracking is
// disabled, bytes are accepted and dropped and the packet position is kept.
// csr_ is a write-only port: index 0 tracking enable, 1 max_x, 2 max_y;
// write it only while no byte is in flight.
// A byte is registered in the input register, and the result of a
// Y-delta byte is loaded from there into the output register, which
// drives rsp_tvalid. Throughput: one byte per cycle, set by the single
// add-and-clamp step between the input and output registers, while no Y
// byte waits for a full output register to drain.
// Reset puts the cursor at 320,240, bounds at 640,480, tracking on, and
// restarts at a header byte.
// A stalled rsp_tready holds the result; header and X bytes keep flowing,
// and the next Y byte waits in the input register, which then drops
// req_tready until the output register drains.
module ps2_mouse_packet_tracker #(
   parameter int POS_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // [7:0] data_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // fields from bit 0: pos_x, pos_y, click, zero fill
   output logic [((2*POS_BITS+2+7)/8)*8-1:0] rsp_tdata,
   input  logic                             csr_wen,
   input  logic [1:0]                       csr_index,
   input  logic [ps2mpt_pkg::CFG_BITS-1:0]  csr_wdata
);
   import ps2mpt_pkg::*;

   cfg_type cfg;

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_data_ff;
   logic                out_valid_ff, out_valid_in;
   logic [POS_BITS-1:0] out_x_ff;
   logic [POS_BITS-1:0] out_y_ff;
   logic [1:0]          out_click_ff;

   logic                emit;
   logic                fire;
   logic                out_free;
   logic [POS_BITS-1:0] res_x;
   logic [POS_BITS-1:0] res_y;
   logic [1:0]          res_click;

   ps2mpt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ps2mpt_core #(
      .POS_BITS (POS_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .fire      (fire),
      .data_byte (in_data_ff),
      .emit      (emit),
      .res_x     (res_x),
      .res_y     (res_y),
      .res_click (res_click)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   // only a result-producing byte needs room downstream
   assign fire       = in_valid_ff && (!emit || out_free);
   assign req_tready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready)
         in_valid_in = 1'b1;
      else if (fire)
         in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (fire && emit)
         out_valid_in = 1'b1;
      else if (rsp_tready)
         out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready)
         in_data_ff <= req_tdata;
      if (fire && emit) begin
         out_x_ff     <= res_x;
         out_y_ff     <= res_y;
         out_click_ff <= res_click;
      end
   end

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[POS_BITS-1:0]            = out_x_ff;
      rsp_tdata[2*POS_BITS-1:POS_BITS]   = out_y_ff;
      rsp_tdata[2*POS_BITS+1:2*POS_BITS] = out_click_ff;
   end

   assign rsp_tvalid = out_valid_ff;

endmodule
